FILE: rtl/pcmcv_pkg.sv
// ----------------------------------------------------------------------------
// PCM converter package
// Shared types, format codes and constants for the PCM to s16 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmcv_pkg;

  localparam int unsigned RAW_W = 64;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned OUT_W = 16;

  typedef enum logic [FMT_W-1:0] {
    FMT_S8  = 3'd0,
    FMT_U8  = 3'd1,
    FMT_U16 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5
  } fmt_t;

  // Float fields normalized to a double layout.
  typedef struct packed {
    logic        sign;
    logic [10:0] expo;
    logic        is_nan;
    logic        is_inf;
    logic [52:0] mant;   // with hidden bit
  } flt_t;

  // Stage one carries the integer result or the decoded float.
  typedef struct packed {
    logic        is_float;
    logic [15:0] int_sample;
    flt_t        flt;
    logic        last;
  } st1_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        clipped;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/pcmcv_if.sv
// ----------------------------------------------------------------------------
// PCM converter channels
// Valid/ready channel interfaces for samples, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcmcv_in_if
  import pcmcv_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  logic             last_in;
  modport source (output valid, raw_sample, last_in, input ready);
  modport sink (input valid, raw_sample, last_in, output ready);
endinterface

interface pcmcv_out_if
  import pcmcv_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;
  logic                    clipped;
  logic                    last_out;
  modport source (output valid, sample_out, clipped, last_out, input ready);
  modport sink (input valid, sample_out, clipped, last_out, output ready);
endinterface

interface pcmcv_cfg_if
  import pcmcv_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [FMT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pcm_sample_to_s16_converter_core.sv
// ----------------------------------------------------------------------------
// PCM sample to s16 converter
// Converts one PCM sample per transfer to signed 16-bit under a format register.
// ----------------------------------------------------------------------------
// Each sample is registered through stages one, two and three before its
// result is offered on out.
// Throughput: one sample per cycle; the three stages advance together and
// hold as a unit while the output stalls, so ready is out.ready or an empty
// last stage.
// Reset: rst (synchronous, active high) empties the pipeline and sets the
// format register to signed 8-bit.
`default_nettype none

module pcm_sample_to_s16_converter_core
  import pcmcv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  pcmcv_cfg_if.sink    cfg,
  pcmcv_in_if.sink     in,
  pcmcv_out_if.source  out
);

  logic [FMT_W-1:0] input_format;

  logic v1, v2, v3;
  st1_t s1;
  // Stage two: the magnitude aligned to an integer, plus overflow flags.
  logic        s2_float, s2_sign, s2_big, s2_nan, s2_last;
  logic [15:0] s2_int, s2_mag;
  logic        s2_lim;
  res_t        s3;
  logic        adv;

  // The pipeline moves whenever the last stage is free or being taken.
  assign adv      = !v3 || out.ready;
  assign in.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= FMT_S8;
    end else if (cfg.valid) begin
      input_format <= cfg.data;
    end
  end

  // Stage one: integer formats resolve here; floats are unpacked into a
  // common double-like layout (single exponents are rebiased by 896).
  st1_t s1_next;
  always_comb begin
    s1_next = '0;
    s1_next.last = in.last_in;
    case (input_format)
      FMT_S8:  s1_next.int_sample = {in.raw_sample[7:0], 8'h00};
      FMT_U8:  s1_next.int_sample = {~in.raw_sample[7], in.raw_sample[6:0], 8'h00};
      FMT_U16: s1_next.int_sample = {~in.raw_sample[15], in.raw_sample[14:0]};
      FMT_S32: s1_next.int_sample = in.raw_sample[31:16];
      FMT_F32: begin
        s1_next.is_float   = 1'b1;
        s1_next.flt.sign   = in.raw_sample[31];
        s1_next.flt.is_nan = (&in.raw_sample[30:23]) && (|in.raw_sample[22:0]);
        s1_next.flt.is_inf = (&in.raw_sample[30:23]) && !(|in.raw_sample[22:0]);
        s1_next.flt.expo   = (in.raw_sample[30:23] == 8'd0) ? 11'd0
                             : {3'd0, in.raw_sample[30:23]} + 11'd896;
        s1_next.flt.mant   = {(in.raw_sample[30:23] != 8'd0),
                              in.raw_sample[22:0], 29'd0};
      end
      FMT_F64: begin
        s1_next.is_float   = 1'b1;
        s1_next.flt.sign   = in.raw_sample[63];
        s1_next.flt.is_nan = (&in.raw_sample[62:52]) && (|in.raw_sample[51:0]);
        s1_next.flt.is_inf = (&in.raw_sample[62:52]) && !(|in.raw_sample[51:0]);
        s1_next.flt.expo   = in.raw_sample[62:52];
        s1_next.flt.mant   = {(in.raw_sample[62:52] != 11'd0), in.raw_sample[51:0]};
      end
      default: s1_next.int_sample = '0;
    endcase
  end

  // Stage two: scaled value = mant * 2^(expo - 1075 + 15). Its integer part
  // is mant >> (1060 - expo). A value of 2^15 or more is out of range, which
  // is expo >= 1023; below expo 1008 the integer part is zero.
  logic [11:0] sh;
  logic [52:0] shifted;
  always_comb begin
    sh = 12'd1060 - {1'b0, s1.flt.expo};
    if (s1.flt.expo < 11'd1008) begin
      shifted = '0;
    end else begin
      shifted = s1.flt.mant >> sh[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_float   <= s1.is_float;
      s2_int     <= s1.int_sample;
      s2_sign    <= s1.flt.sign;
      s2_nan     <= s1.flt.is_nan;
      s2_big     <= s1.flt.is_inf || (s1.flt.expo >= 11'd1023);
      s2_lim     <= (s1.flt.expo == 11'd1023);
      s2_mag     <= shifted[15:0];
      s2_last    <= s1.last;
    end
  end

  // Stage three: sign, saturation and NaN. A negative value whose integer
  // part is exactly 2^15 truncates to -32768 and is in range, whatever its
  // fraction; anything larger clips.
  res_t s3_next;
  always_comb begin
    s3_next.last    = s2_last;
    s3_next.clipped = 1'b0;
    if (!s2_float) begin
      s3_next.sample = s2_int;
    end else if (s2_nan) begin
      s3_next.sample = '0;
    end else if (s2_big) begin
      s3_next.sample  = s2_sign ? 16'h8000 : 16'h7FFF;
      s3_next.clipped = !(s2_sign && s2_lim && s2_mag == 16'h8000);
    end else begin
      s3_next.sample = s2_sign ? (16'd0 - s2_mag) : s2_mag;
    end
  end

  // At expo 1023 the shift is 37, so s2_mag holds the whole integer part
  // and the 2^15 bit lands on bit 15.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s3 <= s3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out.valid      = v3;
  assign out.sample_out = s3.sample;
  assign out.clipped    = s3.clipped;
  assign out.last_out   = s3.last;

endmodule

`default_nettype wire
